### design/spectrum_bar_gravity_peak_core_macros.svh
// assertion macros for the spectrum bar gravity peak core
// used by the port checker; no other dependencies
`ifndef SPECTRUM_BAR_GRAVITY_PEAK_CORE_MACROS_SVH
`define SPECTRUM_BAR_GRAVITY_PEAK_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SBGP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SBGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sbgp_pkg.sv
// shared widths, types and helper functions for the spectrum bar gravity peak core
// no dependencies
package sbgp_pkg;

    localparam int COL_W   = 4;   // column index
    localparam int BIN_W   = 13;  // bin height, Q5.8
    localparam int BIN2_W  = 14;  // doubled bin, Q6.8
    localparam int DT_W    = 16;  // frame time, Q0.16
    localparam int G_W     = 12;  // gravity, whole rows/s^2
    localparam int ROW_W   = 4;   // output row fields
    localparam int H_W     = 13;  // stored height, Q5.8
    localparam int V_W     = 18;  // stored velocity, signed Q9.8
    localparam int GDT_W   = 28;  // gravity * dt
    localparam int DV_W    = 21;  // rounded velocity step
    localparam int SUM_W   = 22;  // velocity before saturation
    localparam int PROD_W  = 35;  // velocity * dt
    localparam int DH_W    = 19;  // rounded height step
    localparam int HS_W    = 20;  // height before clamping

    localparam int NUM_STAGES = 4;
    localparam int ROW_ONE    = 256;

    localparam logic [G_W-1:0] GRAVITY_RESET = 12'd120;
    localparam int RND_Q8  = 128;
    localparam int RND_Q16 = 32768;

    localparam logic signed [SUM_W-1:0] VEL_MAX = 22'sd131071;
    localparam logic signed [SUM_W-1:0] VEL_MIN = -22'sd131072;

    typedef struct packed {
        logic [H_W-1:0] bar_h;
        logic [V_W-1:0] bar_v;
        logic [H_W-1:0] blk_h;
        logic [V_W-1:0] blk_v;
    } t_col_state;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
    } t_stage_tag;

    typedef struct packed {
        logic advance;
        logic accept;
    } t_pipe_ctrl;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] bar_row;
        logic [ROW_W-1:0] blk_row;
    } t_result;

    function automatic logic [V_W-1:0] sat_vel(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        y = x;
        if (x > VEL_MAX) begin
            y = VEL_MAX;
        end else if (x < VEL_MIN) begin
            y = VEL_MIN;
        end
        return y[V_W-1:0];
    endfunction

    // height rounded half up to whole rows, low four bits
    function automatic logic [ROW_W-1:0] to_row(input logic [H_W-1:0] h);
        logic [H_W:0] s;
        s = {1'b0, h} + (H_W + 1)'(RND_Q8);
        return s[8 +: ROW_W];
    endfunction

endpackage

### design/sbgp_state_mem.sv
// per-column state memory with registered read
// entry valid bits make unwritten entries read as zero; uses sbgp_pkg
module sbgp_state_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output sbgp_pkg::t_col_state  o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  sbgp_pkg::t_col_state  i_wr_data
);
    import sbgp_pkg::*;

    t_col_state             r_mem [DEPTH];
    logic [DEPTH-1:0]       r_entry_valid;
    t_col_state             r_rd_data;
    logic                   r_rd_hit;
    logic                   rd_in_range;

    assign rd_in_range = (32'(i_rd_addr) < 32'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_hit      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_entry_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= rd_in_range && r_entry_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

### design/sbgp_update_pipe.sv
// four-stage update of bar and peak block for one column
// reads state from sbgp_state_mem, writes back at the last stage; uses sbgp_pkg
module sbgp_update_pipe #(
    parameter int NUM_COLUMNS = 16,
    parameter int NUM_ROWS    = 16,
    parameter int AW          = 4
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  sbgp_pkg::t_pipe_ctrl                            i_ctrl,
    input  logic [sbgp_pkg::COL_W-1:0]                      i_column_index,
    input  logic [sbgp_pkg::BIN_W-1:0]                      i_bin_height,
    input  logic [sbgp_pkg::DT_W-1:0]                       i_frame_dt,
    input  logic [sbgp_pkg::G_W-1:0]                        i_gravity_rate,
    input  sbgp_pkg::t_col_state                            i_state,
    output sbgp_pkg::t_stage_tag [sbgp_pkg::NUM_STAGES-1:0] o_tags,
    output logic                                            o_wr_en,
    output logic [AW-1:0]                                   o_wr_addr,
    output sbgp_pkg::t_col_state                            o_wr_data,
    output logic                                            o_res_valid,
    output sbgp_pkg::t_result                               o_res
);
    import sbgp_pkg::*;

    localparam logic signed [HS_W-1:0] CEIL_S = HS_W'((NUM_ROWS - 1) * ROW_ONE);
    localparam logic [H_W-1:0]         CEIL_H = H_W'((NUM_ROWS - 1) * ROW_ONE);

    // stage 1: inputs captured, state arriving from memory
    logic                     r_s1_valid, r_s1_in_range;
    logic [COL_W-1:0]         r_s1_col;
    logic [BIN2_W-1:0]        r_s1_bin2;
    logic [DT_W-1:0]          r_s1_dt;
    logic [GDT_W-1:0]         r_s1_gdt;

    // stage 2: velocities after gravity
    logic                     r_s2_valid, r_s2_in_range, r_s2_snap;
    logic [COL_W-1:0]         r_s2_col;
    logic [BIN2_W-1:0]        r_s2_bin2;
    logic [DT_W-1:0]          r_s2_dt;
    logic [H_W-1:0]           r_s2_bar_h, r_s2_blk_h;
    logic signed [V_W-1:0]    r_s2_bar_vf, r_s2_blk_vf;

    // stage 3: velocity times frame time
    logic                     r_s3_valid, r_s3_in_range, r_s3_snap;
    logic [COL_W-1:0]         r_s3_col;
    logic [BIN2_W-1:0]        r_s3_bin2;
    logic [H_W-1:0]           r_s3_bar_h, r_s3_blk_h;
    logic [V_W-1:0]           r_s3_bar_vf, r_s3_blk_vf;
    logic [PROD_W-1:0]        r_s3_p_bar, r_s3_p_blk;

    // stage 4: clamped bar and fallen block
    logic                     r_s4_valid, r_s4_in_range;
    logic [COL_W-1:0]         r_s4_col;
    logic [H_W-1:0]           r_s4_bar_h, r_s4_blk_h_old, r_s4_blk_h_fall;
    logic [V_W-1:0]           r_s4_bar_v, r_s4_blk_v_fall;

    // stage 1 logic
    logic [GDT_W:0]           gdt_rnd;
    logic [DV_W-1:0]          dv;
    logic [V_W-1:0]           bar_vf, blk_vf;
    logic                     bar_snap;

    // stage 2 logic
    logic signed [PROD_W-1:0] p_bar, p_blk;

    // stage 3 logic
    logic [PROD_W-1:0]        p_bar_rnd, p_blk_rnd;
    logic [DH_W-1:0]          dh_bar, dh_blk;
    logic signed [HS_W-1:0]   bar_sum, blk_sum, bar_pre_h;
    logic [V_W-1:0]           bar_pre_v;
    logic [H_W-1:0]           bar_h_c, blk_h_c;
    logic [V_W-1:0]           bar_v_c, blk_v_c;

    // stage 4 logic
    logic                     blk_snap;
    logic [H_W-1:0]           blk_diff;
    logic [V_W-1:0]           blk_v_snap;
    logic [H_W-1:0]           blk_h_fin;
    logic [V_W-1:0]           blk_v_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_s1_valid <= i_ctrl.accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_comb begin
        gdt_rnd  = {1'b0, r_s1_gdt} + (GDT_W + 1)'(RND_Q8);
        dv       = gdt_rnd[GDT_W:8];
        bar_vf   = sat_vel({{(SUM_W - V_W){i_state.bar_v[V_W-1]}}, i_state.bar_v}
                           - {{(SUM_W - DV_W){1'b0}}, dv});
        blk_vf   = sat_vel({{(SUM_W - V_W){i_state.blk_v[V_W-1]}}, i_state.blk_v}
                           - {{(SUM_W - DV_W){1'b0}}, dv});
        bar_snap = ({1'b0, i_state.bar_h} < r_s1_bin2);
    end

    always_comb begin
        p_bar = PROD_W'(r_s2_bar_vf) * PROD_W'($signed({1'b0, r_s2_dt}));
        p_blk = PROD_W'(r_s2_blk_vf) * PROD_W'($signed({1'b0, r_s2_dt}));
    end

    always_comb begin
        p_bar_rnd = r_s3_p_bar + PROD_W'(RND_Q16);
        p_blk_rnd = r_s3_p_blk + PROD_W'(RND_Q16);
        dh_bar    = p_bar_rnd[PROD_W-1:16];
        dh_blk    = p_blk_rnd[PROD_W-1:16];
        bar_sum   = $signed({{(HS_W - H_W){1'b0}}, r_s3_bar_h})
                  + $signed({{(HS_W - DH_W){dh_bar[DH_W-1]}}, dh_bar});
        blk_sum   = $signed({{(HS_W - H_W){1'b0}}, r_s3_blk_h})
                  + $signed({{(HS_W - DH_W){dh_blk[DH_W-1]}}, dh_blk});

        // snap replaces the fall for the bar
        bar_pre_h = r_s3_snap ? $signed({{(HS_W - BIN2_W){1'b0}}, r_s3_bin2}) : bar_sum;
        bar_pre_v = r_s3_snap ? '0 : r_s3_bar_vf;

        priority if (bar_pre_h[HS_W-1]) begin
            bar_h_c = '0;
            bar_v_c = '0;
        end else if (bar_pre_h >= CEIL_S) begin
            bar_h_c = CEIL_H;
            bar_v_c = '0;
        end else begin
            bar_h_c = bar_pre_h[H_W-1:0];
            bar_v_c = bar_pre_v;
        end

        // block keeps its velocity at the ceiling
        priority if (blk_sum[HS_W-1]) begin
            blk_h_c = '0;
            blk_v_c = '0;
        end else if (blk_sum >= CEIL_S) begin
            blk_h_c = CEIL_H;
            blk_v_c = r_s3_blk_vf;
        end else begin
            blk_h_c = blk_sum[H_W-1:0];
            blk_v_c = r_s3_blk_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_s1_in_range <= (32'(i_column_index) < 32'(NUM_COLUMNS));
            r_s1_col      <= i_column_index;
            r_s1_bin2     <= {i_bin_height, 1'b0};
            r_s1_dt       <= i_frame_dt;
            r_s1_gdt      <= GDT_W'(i_gravity_rate) * GDT_W'(i_frame_dt);

            r_s2_in_range <= r_s1_in_range;
            r_s2_col      <= r_s1_col;
            r_s2_bin2     <= r_s1_bin2;
            r_s2_snap     <= bar_snap;
            r_s2_dt       <= r_s1_dt;
            r_s2_bar_h    <= i_state.bar_h;
            r_s2_blk_h    <= i_state.blk_h;
            r_s2_bar_vf   <= bar_vf;
            r_s2_blk_vf   <= blk_vf;

            r_s3_in_range <= r_s2_in_range;
            r_s3_col      <= r_s2_col;
            r_s3_bin2     <= r_s2_bin2;
            r_s3_snap     <= r_s2_snap;
            r_s3_bar_h    <= r_s2_bar_h;
            r_s3_blk_h    <= r_s2_blk_h;
            r_s3_bar_vf   <= r_s2_bar_vf;
            r_s3_blk_vf   <= r_s2_blk_vf;
            r_s3_p_bar    <= p_bar;
            r_s3_p_blk    <= p_blk;

            r_s4_in_range   <= r_s3_in_range;
            r_s4_col        <= r_s3_col;
            r_s4_bar_h      <= bar_h_c;
            r_s4_bar_v      <= bar_v_c;
            r_s4_blk_h_old  <= r_s3_blk_h;
            r_s4_blk_h_fall <= blk_h_c;
            r_s4_blk_v_fall <= blk_v_c;
        end
    end

    // block snaps to a higher bar with five times the jump as velocity
    always_comb begin
        blk_snap   = (r_s4_bar_h > r_s4_blk_h_old);
        blk_diff   = r_s4_bar_h - r_s4_blk_h_old;
        blk_v_snap = {{(V_W - H_W){1'b0}}, blk_diff}
                   + {{(V_W - H_W - 2){1'b0}}, blk_diff, 2'b00};
        blk_h_fin  = blk_snap ? r_s4_bar_h : r_s4_blk_h_fall;
        blk_v_fin  = blk_snap ? blk_v_snap : r_s4_blk_v_fall;
    end

    assign o_wr_en         = i_ctrl.advance && r_s4_valid && r_s4_in_range;
    assign o_wr_addr       = AW'(r_s4_col);
    assign o_wr_data.bar_h = r_s4_bar_h;
    assign o_wr_data.bar_v = r_s4_bar_v;
    assign o_wr_data.blk_h = blk_h_fin;
    assign o_wr_data.blk_v = blk_v_fin;

    assign o_res_valid     = r_s4_valid;
    assign o_res.col       = r_s4_col;
    assign o_res.bar_row   = r_s4_in_range ? to_row(r_s4_bar_h) : '0;
    assign o_res.blk_row   = r_s4_in_range ? to_row(blk_h_fin) : '0;

    assign o_tags[0] = '{valid: r_s1_valid, col: r_s1_col};
    assign o_tags[1] = '{valid: r_s2_valid, col: r_s2_col};
    assign o_tags[2] = '{valid: r_s3_valid, col: r_s3_col};
    assign o_tags[3] = '{valid: r_s4_valid, col: r_s4_col};

endmodule

### design/spectrum_bar_gravity_peak_core.sv
// a result passes the 4 update stages and then the output register, where it waits on stall
// throughput: one request per cycle while the output does not halt the pipe and no request
// hits a column still in the 4-stage update pipe; such a request waits until that column
// is written back
// reset: synchronous, active low; pipe and output empty, gravity 120, all columns read zero
// top level; uses sbgp_pkg, sbgp_state_mem, sbgp_update_pipe
module spectrum_bar_gravity_peak_core #(
    parameter int NUM_COLUMNS = 16,
    parameter int NUM_ROWS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sbgp_pkg::G_W-1:0]     i_cfg_gravity_rate,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sbgp_pkg::COL_W-1:0]   i_column_index,
    input  logic [sbgp_pkg::BIN_W-1:0]   i_bin_height,
    input  logic [sbgp_pkg::DT_W-1:0]    i_frame_dt,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sbgp_pkg::COL_W-1:0]   o_column_out,
    output logic [sbgp_pkg::ROW_W-1:0]   o_bar_top_row,
    output logic [sbgp_pkg::ROW_W-1:0]   o_block_row
);
    import sbgp_pkg::*;

    localparam int AW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    logic [G_W-1:0]              r_gravity_rate;
    logic                        r_out_valid, n_out_valid;
    t_result                     r_out;

    t_pipe_ctrl                  ctrl;
    t_stage_tag [NUM_STAGES-1:0] tags;
    t_col_state                  rd_state;
    t_col_state                  wr_state;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        res_valid;
    t_result                     res;
    logic                        hazard;

    // gravity register, written whenever requested
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity_rate <= GRAVITY_RESET;
        end else if (i_cfg_valid) begin
            r_gravity_rate <= i_cfg_gravity_rate;
        end
    end

    // a column in flight has not yet been written back, so its memory copy is stale;
    // hold off a new request for that column until it leaves the last stage
    always_comb begin
        hazard = 1'b0;
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (tags[i].valid && (tags[i].col == i_column_index)) begin
                hazard = 1'b1;
            end
        end
    end

    // the whole pipe moves together; it only halts when a finished result
    // sits in the last stage and the output register cannot take it
    assign ctrl.advance = !(r_out_valid && i_out_stall && res_valid);
    assign o_in_stall   = !ctrl.advance || hazard;
    assign ctrl.accept  = i_in_valid && !o_in_stall;

    // memory is read at the accept edge; it only reads while the pipe moves,
    // so the state of a stalled stage 1 stays on the read port
    sbgp_state_mem #(
        .DEPTH (NUM_COLUMNS),
        .AW    (AW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ctrl.advance),
        .i_rd_addr (AW'(i_column_index)),
        .o_rd_data (rd_state),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_state)
    );

    // gravity on velocity, velocity times dt, add and clamp, block snap and write back
    sbgp_update_pipe #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS),
        .AW          (AW)
    ) u_update_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_column_index (i_column_index),
        .i_bin_height   (i_bin_height),
        .i_frame_dt     (i_frame_dt),
        .i_gravity_rate (r_gravity_rate),
        .i_state        (rd_state),
        .o_tags         (tags),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_state),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // output register parts the result channel from the pipe
    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.advance && res_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_column_out  = r_out.col;
    assign o_bar_top_row = r_out.bar_row;
    assign o_block_row   = r_out.blk_row;

endmodule

### design/sbgp_checker.sv
// port-level checker for spectrum_bar_gravity_peak_core, bound to the top level
// uses spectrum_bar_gravity_peak_core_macros.svh
module sbgp_checker #(
    parameter int NUM_COLUMNS = 16,
    parameter int NUM_ROWS    = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_column_out,
    input logic [3:0]  o_bar_top_row,
    input logic [3:0]  o_block_row
);
`include "spectrum_bar_gravity_peak_core_macros.svh"

    localparam logic [3:0] ROW_LIMIT = (NUM_ROWS > 16) ? 4'd15 : 4'(NUM_ROWS - 1);
    localparam logic [6:0] COL_LIMIT = 7'(NUM_COLUMNS);

    logic        out_wait;
    logic [11:0] out_bits;
    logic        rows_ok;
    logic        col_absent;
    logic        rows_zero;

    assign out_wait   = o_out_valid && i_out_stall;
    assign out_bits   = {o_column_out, o_bar_top_row, o_block_row};
    assign rows_ok    = (o_bar_top_row <= ROW_LIMIT) && (o_block_row <= ROW_LIMIT);
    assign col_absent = o_out_valid && ({3'b000, o_column_out} >= COL_LIMIT);
    assign rows_zero  = (o_bar_top_row == 4'd0) && (o_block_row == 4'd0);

    // a waiting result is not withdrawn
    `SBGP_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, out_wait, o_out_valid, "result dropped")

    // a waiting result does not change
    `SBGP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable(out_bits), "result changed")

    // rows never exceed the top row of the display
    `SBGP_ASSERT_NOW(a_row_range, i_clk, i_rst_n, o_out_valid, rows_ok, "row beyond display")

    // a column beyond the display returns empty rows
    `SBGP_ASSERT_NOW(a_col_outside, i_clk, i_rst_n, col_absent, rows_zero, "absent column rows")

endmodule

bind spectrum_bar_gravity_peak_core sbgp_checker #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
) u_sbgp_checker (.*);
